// ===== rtl/core/trd_pkg.sv =====
// Shared types and constants for the tablet report event decoder.
// Used by the event generator, the button store and the top level; no dependencies.
package trd_pkg;

  // Input word fields, packed as they arrive
  localparam logic [7:0] ReportIdPen    = 8'h02;
  localparam logic [7:0] StatusPenLimit = 8'hb0;
  localparam logic [7:0] StatusPadMin   = 8'hf0;

  // Dial bits in byte 7 of a pad report
  localparam int unsigned DialLeftUp    = 0;
  localparam int unsigned DialLeftDown  = 1;
  localparam int unsigned DialRightUp   = 4;
  localparam int unsigned DialRightDown = 5;

  // Pen status flag bits
  localparam int unsigned StatusTouch   = 0;
  localparam int unsigned StatusStylus1 = 1;
  localparam int unsigned StatusStylus2 = 2;

  // Step positions: pen reports use all nine, pad reports the first three
  localparam int unsigned StepW      = 4;
  localparam int unsigned NumSteps   = 9;
  localparam logic [StepW-1:0] StepPadDial = 4'd0;
  localparam logic [StepW-1:0] StepPadKey  = 4'd1;
  localparam logic [StepW-1:0] StepPadSync = 4'd2;
  localparam logic [StepW-1:0] StepLast    = 4'd8;

  localparam int unsigned ButtonW = 5;
  localparam int unsigned ValueW  = 17;
  localparam int unsigned MapW    = 24;

  typedef enum logic [3:0] {
    KindTool     = 4'd0,
    KindPressure = 4'd1,
    KindStylus1  = 4'd2,
    KindStylus2  = 4'd3,
    KindX        = 4'd4,
    KindY        = 4'd5,
    KindTiltX    = 4'd6,
    KindTiltY    = 4'd7,
    KindSync     = 4'd8,
    KindWheel    = 4'd9,
    KindHWheel   = 4'd10,
    KindPadKey   = 4'd11
  } event_kind_e;

  // One input report
  typedef struct packed {
    logic [1:0] device_slot;
    logic [7:0] report_id;
    logic [7:0] status;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
    logic [7:0] byte_8;
    logic [7:0] byte_9;
  } item_t;

  // One output event
  typedef struct packed {
    logic [1:0]               event_slot;
    logic                     to_pad;
    event_kind_e              event_kind;
    logic [ButtonW-1:0]       button_number;
    logic signed [ValueW-1:0] event_value;
    logic                     last_of_run;
  } event_t;

  // Sequencing status from the generator
  typedef struct packed {
    logic             has_event;
    logic             is_last;
    logic [StepW-1:0] step;
  } gen_status_t;

  // Update of the remembered pad button
  typedef struct packed {
    logic               en;
    logic [ButtonW-1:0] data;
  } btn_wr_t;

endpackage

// ===== rtl/core/trd_event_gen.sv =====
// Combinational event generator: picks the event for the current step of one report.
// Depends on trd_pkg.
module trd_event_gen (
  input  trd_pkg::item_t                 item_i,
  input  logic [trd_pkg::StepW-1:0]      step_i,
  input  logic [trd_pkg::ButtonW-1:0]    held_i,
  output trd_pkg::gen_status_t           status_o,
  output trd_pkg::event_t                event_o,
  output trd_pkg::btn_wr_t               btn_wr_o
);

  logic                               is_rid;
  logic                               is_pen;
  logic                               is_pad;
  logic [trd_pkg::MapW-1:0]           map;
  logic                               map_any;
  logic [trd_pkg::ButtonW-1:0]        map_pos;
  logic                               left_on;
  logic                               right_on;
  logic                               dial;
  logic signed [trd_pkg::ValueW-1:0]  dial_val;
  logic [trd_pkg::NumSteps-1:0]       exist;
  logic [trd_pkg::NumSteps-1:0]       cand;
  logic [trd_pkg::StepW-1:0]          cur;
  logic                               found;
  logic                               more;

  // Report classification
  assign is_rid = (item_i.report_id == trd_pkg::ReportIdPen);
  assign is_pen = is_rid && (item_i.status < trd_pkg::StatusPenLimit);
  assign is_pad = is_rid && (item_i.status >= trd_pkg::StatusPadMin);

  assign map     = {item_i.byte_4, item_i.byte_3, item_i.byte_2};
  assign map_any = (map != '0);

  // Lowest set button bit, 1-based
  always_comb begin
    map_pos = '0;
    for (int i = trd_pkg::MapW - 1; i >= 0; i--) begin
      if (map[i]) begin
        map_pos = trd_pkg::ButtonW'(i + 1);
      end
    end
  end

  // Dial decode, left dial first and the up bit first within a dial
  assign left_on  = item_i.byte_7[trd_pkg::DialLeftUp] || item_i.byte_7[trd_pkg::DialLeftDown];
  assign right_on = item_i.byte_7[trd_pkg::DialRightUp] ||
                    item_i.byte_7[trd_pkg::DialRightDown];
  assign dial     = left_on || right_on;

  always_comb begin
    if (left_on) begin
      dial_val = item_i.byte_7[trd_pkg::DialLeftUp] ? 17'sd1 : -17'sd1;
    end else begin
      dial_val = item_i.byte_7[trd_pkg::DialRightUp] ? 17'sd1 : -17'sd1;
    end
  end

  // Which steps give an event for this report
  always_comb begin
    exist = '0;
    if (is_pen) begin
      exist = '1;
      exist[trd_pkg::KindPressure] = item_i.status[trd_pkg::StatusTouch];
    end else if (is_pad) begin
      exist[trd_pkg::StepPadDial] = dial;
      exist[trd_pkg::StepPadKey]  = map_any || (!dial && (held_i != '0));
      exist[trd_pkg::StepPadSync] = 1'b1;
    end
  end

  // First existing step at or after the current one, and whether another follows
  always_comb begin
    cur   = '0;
    found = 1'b0;
    more  = 1'b0;
    for (int i = 0; i < trd_pkg::NumSteps; i++) begin
      cand[i] = exist[i] && (trd_pkg::StepW'(i) >= step_i);
    end
    for (int i = trd_pkg::NumSteps - 1; i >= 0; i--) begin
      if (cand[i]) begin
        if (found) begin
          more = 1'b1;
        end
        found = 1'b1;
        cur   = trd_pkg::StepW'(i);
      end
    end
  end

  assign status_o.has_event = found;
  assign status_o.is_last   = !more;
  assign status_o.step      = cur;

  // Event contents for the chosen step
  always_comb begin
    event_o.event_slot    = item_i.device_slot;
    event_o.to_pad        = is_pad;
    event_o.event_kind    = trd_pkg::KindSync;
    event_o.button_number = '0;
    event_o.event_value   = 17'sd1;
    event_o.last_of_run   = !more;
    btn_wr_o.en           = 1'b0;
    btn_wr_o.data         = '0;
    if (is_pad) begin
      case (cur)
        trd_pkg::StepPadDial: begin
          event_o.event_kind  = left_on ? trd_pkg::KindWheel : trd_pkg::KindHWheel;
          event_o.event_value = dial_val;
        end
        trd_pkg::StepPadKey: begin
          event_o.event_kind    = trd_pkg::KindPadKey;
          event_o.button_number = map_any ? map_pos : held_i;
          event_o.event_value   = map_any ? 17'sd1 : 17'sd0;
          btn_wr_o.en           = 1'b1;
          btn_wr_o.data         = map_any ? map_pos : '0;
        end
        default: begin
          event_o.event_kind = trd_pkg::KindSync;
        end
      endcase
    end else begin
      case (cur)
        4'd0: begin
          event_o.event_kind  = trd_pkg::KindTool;
          event_o.event_value = {16'd0, item_i.status[trd_pkg::StatusTouch]};
        end
        4'd1: begin
          event_o.event_kind  = trd_pkg::KindPressure;
          event_o.event_value = {1'b0, item_i.byte_7, item_i.byte_6};
        end
        4'd2: begin
          event_o.event_kind  = trd_pkg::KindStylus1;
          event_o.event_value = {16'd0, item_i.status[trd_pkg::StatusStylus1]};
        end
        4'd3: begin
          event_o.event_kind  = trd_pkg::KindStylus2;
          event_o.event_value = {16'd0, !item_i.status[trd_pkg::StatusStylus1] &&
                                        item_i.status[trd_pkg::StatusStylus2]};
        end
        4'd4: begin
          event_o.event_kind  = trd_pkg::KindX;
          event_o.event_value = {1'b0, item_i.byte_3, item_i.byte_2};
        end
        4'd5: begin
          event_o.event_kind  = trd_pkg::KindY;
          event_o.event_value = {1'b0, item_i.byte_5, item_i.byte_4};
        end
        4'd6: begin
          event_o.event_kind  = trd_pkg::KindTiltX;
          event_o.event_value = {{9{item_i.byte_8[7]}}, item_i.byte_8};
        end
        4'd7: begin
          event_o.event_kind  = trd_pkg::KindTiltY;
          event_o.event_value = {{9{item_i.byte_9[7]}}, item_i.byte_9};
        end
        default: begin
          event_o.event_kind = trd_pkg::KindSync;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/trd_button_store.sv =====
// Per-slot store of the pad button pressed last, with one read and one write port.
// Depends on trd_pkg.
module trd_button_store #(
  parameter int unsigned DEVICE_SLOTS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    slot_i,
  input  trd_pkg::btn_wr_t              wr_i,
  output logic [trd_pkg::ButtonW-1:0]   held_o
);

  localparam int unsigned IdxW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;

  logic [trd_pkg::ButtonW-1:0] last_button_q [DEVICE_SLOTS];
  logic                        slot_ok;
  logic [IdxW-1:0]             idx;

  // Slots beyond the store read as no button and are never written
  assign slot_ok  = (32'(slot_i) < DEVICE_SLOTS);
  assign idx      = IdxW'(slot_i);
  assign held_o   = slot_ok ? last_button_q[idx] : '0;

  // Storage registers, cleared at reset to no button held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        last_button_q[i] <= '0;
      end
    end else if (wr_i.en && slot_ok) begin
      last_button_q[idx] <= wr_i.data;
    end
  end

endmodule

// ===== rtl/core/tablet_report_event_decoder.sv =====
// Top level of the tablet report event decoder: report register, step counter, event register.
// Depends on trd_pkg, trd_event_gen and trd_button_store.

// A report word is held in an input register while its events are sent out one per cycle,
// unless the output stalls, through a registered output: a pen report sends nine events (eight
// without contact), a pad report one to three, and a report that is neither sends nothing.
// The next report is taken in the same cycle as the last event of the current one, so a
// stream of pen reports runs at one event per cycle while the output is not stalled; the step
// counter walks over the report's events. Pad button numbers come out 1-based; each slot remembers the
// button pressed last so that a later empty pad report can send its release.
module tablet_report_event_decoder #(
  parameter int unsigned DEVICE_SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // report_id, status, byte_2 .. byte_9
  input  logic [79:0] s_tdata_i,
  // device_slot
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // button_number, event_value, 2 zero bits
  output logic [23:0] m_tdata_o,
  // event_slot, to_pad, event_kind
  output logic [6:0]  m_tuser_o,
  // last_of_run
  output logic        m_tlast_o
);

  trd_pkg::item_t              item_q, item_d;
  logic                        item_valid_q, item_valid_d;
  logic [trd_pkg::StepW-1:0]   step_q, step_d;
  trd_pkg::event_t             out_q, out_d;
  logic                        out_valid_q, out_valid_d;
  trd_pkg::gen_status_t        gen_status;
  trd_pkg::event_t             gen_event;
  trd_pkg::btn_wr_t            gen_wr;
  trd_pkg::btn_wr_t            store_wr;
  logic [trd_pkg::ButtonW-1:0] held;
  logic                        out_ready;
  logic                        push;
  logic                        consume;
  logic                        accept;

  trd_event_gen u_gen (
    .item_i   (item_q),
    .step_i   (step_q),
    .held_i   (held),
    .status_o (gen_status),
    .event_o  (gen_event),
    .btn_wr_o (gen_wr)
  );

  trd_button_store #(
    .DEVICE_SLOTS (DEVICE_SLOTS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .slot_i (item_q.device_slot),
    .wr_i   (store_wr),
    .held_o (held)
  );

  // Handshake decisions
  assign out_ready  = !out_valid_q || m_tready_i;
  assign push       = item_valid_q && gen_status.has_event && out_ready;
  assign consume    = item_valid_q && (!gen_status.has_event || (out_ready && gen_status.is_last));
  assign s_tready_o = !item_valid_q || consume;
  assign accept     = s_tvalid_i && s_tready_o;

  assign store_wr.en   = push && gen_wr.en;
  assign store_wr.data = gen_wr.data;

  // Report register and step counter
  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    step_d       = step_q;
    if (consume) begin
      item_valid_d = 1'b0;
    end else if (push) begin
      step_d = gen_status.step + trd_pkg::StepW'(1);
    end
    if (accept) begin
      item_valid_d = 1'b1;
      item_d       = {s_tuser_i, s_tdata_i[7:0], s_tdata_i[15:8], s_tdata_i[23:16],
                      s_tdata_i[31:24], s_tdata_i[39:32], s_tdata_i[47:40],
                      s_tdata_i[55:48], s_tdata_i[63:56], s_tdata_i[71:64],
                      s_tdata_i[79:72]};
      step_d       = '0;
    end
  end

  // Output event register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready) begin
      out_valid_d = push;
      out_d       = gen_event;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_q.event_value, out_q.button_number};
  assign m_tuser_o  = {out_q.event_kind, out_q.to_pad, out_q.event_slot};
  assign m_tlast_o  = out_q.last_of_run;

`ifndef ASSERT_OFF
  // Every run of events closes with a sync.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> out_q.event_kind == trd_pkg::KindSync)
    else $error("run closed by an event other than sync");

  // Pad key events go to the pad device and carry a real button number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && out_q.event_kind == trd_pkg::KindPadKey |->
      out_q.to_pad && out_q.button_number != '0)
    else $error("pad key event without a button or on the pen device");

  // Only pad key events carry a button number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && out_q.event_kind != trd_pkg::KindPadKey |-> out_q.button_number == '0)
    else $error("button number on a non-key event");

  // The step counter never runs past the sync step of a held report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q |-> step_q <= trd_pkg::StepLast)
    else $error("step counter past the last step");
`endif

endmodule
